// ----- hdl/stkm_pkg.sv -----
// Shared types and codes for the stack machine core.
// Holds the command/response beat structs, command, status and opcode constants.
// No dependencies.
package stkm_pkg;

  localparam int WORD_W = 32;
  localparam int CFG_W  = 13;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] address;
    logic [31:0] write_word;
    logic [7:0]  input_byte;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_word;
    logic        char_valid;
    logic [7:0]  char_out;
    logic [11:0] next_ip;
    logic [12:0] stack_level;
  } rsp_t;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALTED  = 3'd1;
  localparam logic [2:0] ST_BAD_OP  = 3'd2;
  localparam logic [2:0] ST_ADDR    = 3'd3;
  localparam logic [2:0] ST_STACK   = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  localparam logic [6:0] UOP_POP    = 7'd0;
  localparam logic [6:0] UOP_PUSH   = 7'd1;
  localparam logic [6:0] UOP_PUSHIP = 7'd2;
  localparam logic [6:0] UOP_PUSHSP = 7'd3;
  localparam logic [6:0] UOP_LOAD   = 7'd4;
  localparam logic [6:0] UOP_STORE  = 7'd5;
  localparam logic [6:0] UOP_JUMP   = 7'd6;
  localparam logic [6:0] UOP_NOT    = 7'd7;
  localparam logic [6:0] UOP_PUTB   = 7'd8;
  localparam logic [6:0] UOP_GETB   = 7'd9;
  localparam logic [6:0] UOP_HALT   = 7'd10;

  localparam logic [6:0] BOP_ADD = 7'd0;
  localparam logic [6:0] BOP_SUB = 7'd1;
  localparam logic [6:0] BOP_MUL = 7'd2;
  localparam logic [6:0] BOP_DIV = 7'd3;
  localparam logic [6:0] BOP_AND = 7'd4;
  localparam logic [6:0] BOP_OR  = 7'd5;
  localparam logic [6:0] BOP_XOR = 7'd6;
  localparam logic [6:0] BOP_EQ  = 7'd7;
  localparam logic [6:0] BOP_LT  = 7'd8;

endpackage

// ----- hdl/stkm_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module stkm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/stkm_div.sv -----
// Iterative signed truncating divider, one quotient bit per cycle.
// Divide by zero gives zero. Depends on stkm_pkg.
module stkm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [stkm_pkg::WORD_W-1:0] dividend,
  input  logic [stkm_pkg::WORD_W-1:0] divisor,
  output logic                      done,
  output logic [stkm_pkg::WORD_W-1:0] quotient
);
  import stkm_pkg::*;

  localparam int CW = $clog2(WORD_W);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvs;
  logic              neg;
  logic              zero;
  logic [WORD_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem, quo[WORD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
        dvs  <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
        neg  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        zero <= divisor == '0;
      end else if (busy) begin
        rem <= ge ? WORD_W'(rem_sh - {1'b0, dvs}) : rem_sh[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = zero ? '0 : (neg ? (~quo + 1'b1) : quo);
endmodule

// ----- hdl/stack_machine_core.sv -----
// Stack machine core: program and downward-growing stack share one word store
// held in a single RAM with a registered read. A write command goes to the finish
// state and a read command through the read state; a step runs fetch, top, second,
// execute and finish, plus a load or divide wait; all reads share the one RAM read
// port and the divider is bit-serial. Config writes are taken while idle.
module stack_machine_core #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  stkm_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output stkm_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [stkm_pkg::CFG_W-1:0] cfg_data
);
  import stkm_pkg::*;

  localparam int AW       = $clog2(STORE_DEPTH);
  localparam int NW       = $clog2(STORE_DEPTH + 1);
  localparam int RST_SIZE = (STORE_DEPTH < 4096) ? STORE_DEPTH : 4096;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_FETCH = 9'b000000100,
    S_TOP   = 9'b000001000,
    S_SEC   = 9'b000010000,
    S_EXEC  = 9'b000100000,
    S_LOAD  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t            state;
  logic [NW-1:0]     size;
  logic [NW-1:0]     sp;
  logic [AW-1:0]     ip;
  logic              halted;
  cmd_t              item;
  logic [WORD_W-1:0] instr;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] a;
  logic              wr_pend;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [NW-1:0]     sp_new;
  logic [AW-1:0]     ip_new;
  logic [2:0]        status_q;
  logic [WORD_W-1:0] rd_q;
  logic              cv_q;
  logic [7:0]        co_q;
  logic              halt_set;

  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_q;

  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              ram_we;

  logic [31:0]       cfg_wide;
  logic [NW-1:0]     cfg_size;
  logic              addr_ok;
  logic [NW-1:0]     ip_inc;
  logic [AW-1:0]     nip;
  logic [NW-1:0]     sp_inc1;
  logic [NW-1:0]     sp_inc2;
  logic [NW-1:0]     sp_dec;
  logic [NW-1:0]     depth;
  logic [6:0]        op;
  logic [6:0]        fop;
  logic [2:0]        fetch_fault;
  logic [WORD_W-1:0] mul_lo;
  logic [WORD_W-1:0] alu_res;
  logic              a_bad;
  logic              b_bad;

  // clamp memory_words into 1..STORE_DEPTH
  assign cfg_wide = 32'(cfg_data);
  always_comb begin
    priority if (cfg_wide == 32'd0) begin
      cfg_size = NW'(1);
    end else if (cfg_wide > 32'(STORE_DEPTH)) begin
      cfg_size = NW'(STORE_DEPTH);
    end else begin
      cfg_size = NW'(cfg_wide);
    end
  end

  assign cmd_stall = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = state == S_IDLE;

  assign addr_ok = 32'(cmd.address) < 32'(size);
  assign ip_inc  = NW'(ip) + 1'b1;
  assign nip     = (ip_inc >= size) ? '0 : AW'(ip_inc);
  assign sp_inc1 = sp + 1'b1;
  assign sp_inc2 = sp + NW'(2);
  assign sp_dec  = sp - 1'b1;
  assign depth   = size - sp;
  assign op      = instr[30:24];
  assign a_bad   = a >= 32'(size);
  assign b_bad   = b >= 32'(size);

  // decode checks on the fetched word, unknown op before stack depth
  assign fop = ram_rdata[30:24];
  always_comb begin
    fetch_fault = ST_OK;
    if (ram_rdata[WORD_W-1]) begin
      priority if (fop > BOP_LT) fetch_fault = ST_BAD_OP;
      else if (depth < NW'(2)) fetch_fault = ST_STACK;
    end else begin
      priority if (fop > UOP_HALT) begin
        fetch_fault = ST_BAD_OP;
      end else if ((fop == UOP_POP || fop == UOP_LOAD || fop == UOP_NOT || fop == UOP_PUTB)
                   && depth == '0) begin
        fetch_fault = ST_STACK;
      end else if ((fop == UOP_STORE || fop == UOP_JUMP) && depth < NW'(2)) begin
        fetch_fault = ST_STACK;
      end else if ((fop == UOP_PUSH || fop == UOP_PUSHIP || fop == UOP_PUSHSP ||
                    fop == UOP_GETB) && sp == '0) begin
        fetch_fault = ST_STACK;
      end
    end
  end

  assign mul_lo = a * b;

  always_comb begin
    unique case (op)
      BOP_ADD: alu_res = a + b;
      BOP_SUB: alu_res = a - b;
      BOP_MUL: alu_res = mul_lo;
      BOP_AND: alu_res = a & b;
      BOP_OR:  alu_res = a | b;
      BOP_XOR: alu_res = a ^ b;
      BOP_EQ:  alu_res = WORD_W'(a == b);
      BOP_LT:  alu_res = WORD_W'($signed(a) < $signed(b));
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:  ram_raddr = (cmd.command == CMD_READ) ? AW'(cmd.address) : ip;
      S_FETCH: ram_raddr = AW'(sp);
      S_TOP:   ram_raddr = AW'(sp_inc1);
      S_EXEC:  ram_raddr = AW'(b);
      default: ram_raddr = '0;
    endcase
  end

  assign ram_we = (state == S_FIN) && wr_pend;

  stkm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stkm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size      <= NW'(RST_SIZE);
      sp        <= NW'(RST_SIZE);
      ip        <= '0;
      halted    <= 1'b0;
      rsp_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= (state == S_EXEC) && instr[WORD_W-1] && (op == BOP_DIV);
      // the finish state loads the next beat itself
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            size <= cfg_size;
            sp   <= cfg_size;
          end else if (cmd_valid) begin
            item     <= cmd;
            wr_pend  <= (cmd.command == CMD_WRITE) && addr_ok;
            wr_addr  <= AW'(cmd.address);
            wr_data  <= cmd.write_word;
            sp_new   <= sp;
            ip_new   <= ip;
            rd_q     <= '0;
            cv_q     <= 1'b0;
            co_q     <= '0;
            halt_set <= 1'b0;
            unique case (cmd.command)
              CMD_WRITE: begin
                status_q <= addr_ok ? ST_OK : ST_ADDR;
                state    <= S_FIN;
              end
              CMD_READ: begin
                status_q <= addr_ok ? ST_OK : ST_ADDR;
                state    <= addr_ok ? S_RD : S_FIN;
              end
              CMD_STEP: begin
                priority if (halted) begin
                  status_q <= ST_IGNORED;
                  state    <= S_FIN;
                end else if (NW'(ip) >= size) begin
                  status_q <= ST_ADDR;
                  state    <= S_FIN;
                end else begin
                  status_q <= ST_OK;
                  state    <= S_FETCH;
                end
              end
              default: begin
                status_q <= ST_OK;
                state    <= S_FIN;
              end
            endcase
          end
        end
        S_RD: begin
          rd_q  <= ram_rdata;
          state <= S_FIN;
        end
        S_FETCH: begin
          instr <= ram_rdata;
          if (fetch_fault != ST_OK) begin
            status_q <= fetch_fault;
            state    <= S_FIN;
          end else begin
            state <= S_TOP;
          end
        end
        S_TOP: begin
          b     <= ram_rdata;
          state <= S_SEC;
        end
        S_SEC: begin
          a     <= ram_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (instr[WORD_W-1]) begin
            if (op == BOP_DIV) begin
              state <= S_DIV;
            end else begin
              wr_pend <= 1'b1;
              wr_addr <= AW'(sp_inc1);
              wr_data <= alu_res;
              sp_new  <= sp_inc1;
              ip_new  <= nip;
              state   <= S_FIN;
            end
          end else begin
            state <= (op == UOP_LOAD && !b_bad) ? S_LOAD : S_FIN;
            unique case (op)
              UOP_POP: begin
                sp_new <= sp_inc1;
                ip_new <= nip;
              end
              UOP_PUSH: begin
                wr_pend <= 1'b1;
                wr_addr <= AW'(sp_dec);
                wr_data <= {8'd0, instr[23:0]};
                sp_new  <= sp_dec;
                ip_new  <= nip;
              end
              UOP_PUSHIP: begin
                wr_pend <= 1'b1;
                wr_addr <= AW'(sp_dec);
                wr_data <= WORD_W'(ip);
                sp_new  <= sp_dec;
                ip_new  <= nip;
              end
              UOP_PUSHSP: begin
                wr_pend <= 1'b1;
                wr_addr <= AW'(sp_dec);
                wr_data <= WORD_W'(sp);
                sp_new  <= sp_dec;
                ip_new  <= nip;
              end
              UOP_LOAD: begin
                if (b_bad) begin
                  status_q <= ST_ADDR;
                end else begin
                  ip_new <= nip;
                end
              end
              UOP_STORE: begin
                if (a_bad) begin
                  status_q <= ST_ADDR;
                end else begin
                  wr_pend <= 1'b1;
                  wr_addr <= AW'(a);
                  wr_data <= b;
                  sp_new  <= sp_inc2;
                  ip_new  <= nip;
                end
              end
              UOP_JUMP: begin
                if (b != '0 && a_bad) begin
                  status_q <= ST_ADDR;
                end else begin
                  sp_new <= sp_inc2;
                  ip_new <= (b != '0) ? AW'(a) : nip;
                end
              end
              UOP_NOT: begin
                wr_pend <= 1'b1;
                wr_addr <= AW'(sp);
                wr_data <= WORD_W'(b == '0);
                ip_new  <= nip;
              end
              UOP_PUTB: begin
                cv_q   <= 1'b1;
                co_q   <= b[7:0];
                sp_new <= sp_inc1;
                ip_new <= nip;
              end
              UOP_GETB: begin
                wr_pend <= 1'b1;
                wr_addr <= AW'(sp_dec);
                wr_data <= WORD_W'(item.input_byte);
                sp_new  <= sp_dec;
                ip_new  <= nip;
              end
              UOP_HALT: begin
                halt_set <= 1'b1;
                status_q <= ST_HALTED;
              end
              default: ;
            endcase
          end
        end
        S_LOAD: begin
          wr_pend <= 1'b1;
          wr_addr <= AW'(sp);
          wr_data <= ram_rdata;
          state   <= S_FIN;
        end
        S_DIV: begin
          if (div_done) begin
            wr_pend <= 1'b1;
            wr_addr <= AW'(sp_inc1);
            wr_data <= div_q;
            sp_new  <= sp_inc1;
            ip_new  <= nip;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          // commit is idempotent, so it may repeat while the output beat waits
          sp <= sp_new;
          ip <= ip_new;
          if (halt_set) halted <= 1'b1;
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= status_q;
            rsp.read_word   <= rd_q;
            rsp.char_valid  <= cv_q;
            rsp.char_out    <= co_q;
            rsp.next_ip     <= 12'(ip_new);
            rsp.stack_level <= 13'(sp_new);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_sp_in_range: assert property (@(posedge clk) disable iff (rst) sp <= size)
    else $error("stack pointer above store size");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide wait");
  a_char_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.char_valid |-> rsp.status == ST_OK)
    else $error("put byte beat with fault status");
`endif

endmodule
